>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FFBA_ASSERT_IMPL(lbl, clk, rst, ant, con, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NEXT(lbl, clk, rst, ant, con, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

>>> rtl/ffba_pkg.sv
`timescale 1ns / 1ps
package ffba_pkg;

   localparam int WALK_W = 14;
   localparam int SIZE_W = 12;

   localparam logic [2:0] HDR_TAG = 3'd6;
   localparam logic [WALK_W-1:0] HDR_LEN = 14'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE = 3'd1;
   localparam logic [2:0] ST_NO_MEM   = 3'd2;
   localparam logic [2:0] ST_BAD_PTR  = 3'd3;
   localparam logic [2:0] ST_DOUBLE   = 3'd4;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [15:0] request_size;
      logic [15:0] release_offset;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] granted_offset;
   } rsp_type;

   function automatic logic [15:0] hdr_make(logic [SIZE_W-1:0] size, logic used);
      hdr_make = {HDR_TAG, used, size};
   endfunction

endpackage

>>> rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// steps, request accept to reply: allocate runs S_A_INIT, S_A_ISSUE, then S_A_EVAL for each
//   header visited (and S_A_SPLIT on a split); free runs S_F_CHK, S_M_ISSUE, then the merge
//   walk; size and out-of-region pointer errors skip to S_DONE, untagged and double free via S_F_CHK
// throughput: one request at a time, the next one is taken as the reply goes out; each walk
//   step waits on the single read port of the header memory
// reset: synchronous; after reset a clearing pass zeroes every word of the header memory
//   and no request is taken until it ends
module first_fit_block_allocator #(
   parameter int REGION_BYTES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ffba_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ffba_pkg::rsp_type rsp_payload
);
   import ffba_pkg::*;

   localparam int AW = $clog2(REGION_BYTES);
   localparam logic [WALK_W-1:0] REGION_W = WALK_W'(REGION_BYTES);
   localparam logic [WALK_W-1:0] WALK_END = WALK_W'(REGION_BYTES - 2);
   localparam logic [15:0] MAX_REQ = 16'(REGION_BYTES - 2);
   localparam logic [15:0] REGION_16 = 16'(REGION_BYTES);
   localparam logic [SIZE_W-1:0] FULL_SIZE = SIZE_W'(REGION_BYTES - 2);
   localparam logic [AW-1:0] CLR_LAST = AW'(REGION_BYTES - 1);

   typedef enum logic [10:0] {
      S_CLEAR   = 11'b00000000001,
      S_IDLE    = 11'b00000000010,
      S_A_INIT  = 11'b00000000100,
      S_A_ISSUE = 11'b00000001000,
      S_A_EVAL  = 11'b00000010000,
      S_A_SPLIT = 11'b00000100000,
      S_F_CHK   = 11'b00001000000,
      S_M_ISSUE = 11'b00010000000,
      S_M_CUR   = 11'b00100000000,
      S_M_J     = 11'b01000000000,
      S_DONE    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [WALK_W-1:0] walk_ff, walk_in;       // current header offset
   logic [WALK_W-1:0] jp_ff, jp_in;           // merge look-ahead offset
   logic [SIZE_W-1:0] sacc_ff, sacc_in;       // merged size so far
   logic [3:0] hi_ff, hi_in;                  // tag and in-use bits of merge head
   logic [SIZE_W-1:0] rsize_ff, rsize_in;     // requested size
   logic [AW-1:0] idx_ff, idx_in;             // header being freed
   logic [AW-1:0] split_addr_ff, split_addr_in;
   logic [15:0] split_data_ff, split_data_in;
   logic [2:0] res_status_ff, res_status_in;
   logic [11:0] res_granted_ff, res_granted_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff, rsp_payload_in;

   // header memory ports
   logic rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [15:0] rd_data, wr_data;

   ffba_hdr_ram #(.DEPTH(REGION_BYTES), .AW(AW)) u_ram (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   // decoded header fields of the last read
   logic [SIZE_W-1:0] h_size;
   logic h_used;
   logic [2:0] h_tag;
   assign h_size = rd_data[11:0];
   assign h_used = rd_data[12];
   assign h_tag  = rd_data[15:13];

   logic [15:0] free_idx;
   logic [WALK_W-1:0] step_next;   // walk + 2 + size of header just read
   logic [WALK_W-1:0] split_nx;
   logic [SIZE_W-1:0] rem;
   logic [SIZE_W-1:0] s_grow;      // merged size after absorbing a free neighbor
   logic [WALK_W-1:0] j_next;
   logic [WALK_W-1:0] acc_next;    // walk + 2 + merged size, or size of header just read outside S_M_J
   logic [WALK_W-1:0] adv;         // where the merge walk goes next
   logic adv_go;
   logic out_free;

   assign free_idx  = req_payload.release_offset - 16'd2;
   assign step_next = walk_ff + HDR_LEN + WALK_W'(h_size);
   assign split_nx  = walk_ff + HDR_LEN + WALK_W'(rsize_ff);
   assign rem       = h_size - rsize_ff;
   assign s_grow    = sacc_ff + SIZE_W'(2) + h_size;
   assign j_next    = jp_ff + HDR_LEN + WALK_W'(h_size);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      adv = step_next;
      if (state_ff == S_M_J) begin
         if (h_used) begin
            adv = walk_ff + HDR_LEN + WALK_W'(sacc_ff);
         end else begin
            adv = walk_ff + HDR_LEN + WALK_W'(s_grow);
         end
      end
   end
   assign acc_next = adv;
   assign adv_go   = acc_next < REGION_W;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      walk_in        = walk_ff;
      jp_in          = jp_ff;
      sacc_in        = sacc_ff;
      hi_in          = hi_ff;
      rsize_in       = rsize_ff;
      idx_in         = idx_ff;
      split_addr_in  = split_addr_ff;
      split_data_in  = split_data_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      rd_en          = 1'b0;
      rd_addr        = walk_ff[AW-1:0];
      wr_en          = 1'b0;
      wr_addr        = walk_ff[AW-1:0];
      wr_data        = rd_data;
      req_stall      = 1'b1;

      // output register drains independently of the walk
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            // zero one header a cycle
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = 16'd0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               res_granted_in = 12'd0;
               walk_in        = '0;
               if (req_payload.operation == OP_FREE) begin
                  if (free_idx >= REGION_16) begin
                     res_status_in = ST_BAD_PTR;
                     state_in      = S_DONE;
                  end else begin
                     idx_in   = free_idx[AW-1:0];
                     rd_en    = 1'b1;
                     rd_addr  = free_idx[AW-1:0];
                     state_in = S_F_CHK;
                  end
               end else begin
                  if (req_payload.request_size == 16'd0 ||
                      req_payload.request_size > MAX_REQ) begin
                     res_status_in = ST_BAD_SIZE;
                     state_in      = S_DONE;
                  end else begin
                     rsize_in = req_payload.request_size[11:0];
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = S_A_INIT;
                  end
               end
            end
         end
         S_A_INIT: begin
            // first allocate sets up the region as one free block
            if (h_tag != HDR_TAG) begin
               wr_en   = 1'b1;
               wr_addr = '0;
               wr_data = hdr_make(FULL_SIZE, 1'b0);
            end
            state_in = S_A_ISSUE;
         end
         S_A_ISSUE: begin
            rd_en    = 1'b1;
            rd_addr  = walk_ff[AW-1:0];
            state_in = S_A_EVAL;
         end
         S_A_EVAL: begin
            if (!h_used && h_size >= rsize_ff) begin
               res_status_in  = ST_OK;
               res_granted_in = 12'(walk_ff + HDR_LEN);
               wr_en          = 1'b1;
               wr_addr        = walk_ff[AW-1:0];
               if (rem > SIZE_W'(2)) begin
                  wr_data = hdr_make(rsize_ff, 1'b1);
                  if (split_nx < REGION_W) begin
                     split_addr_in = split_nx[AW-1:0];
                     split_data_in = hdr_make(rem - SIZE_W'(2), 1'b0);
                     state_in      = S_A_SPLIT;
                  end else begin
                     state_in = S_DONE;
                  end
               end else begin
                  wr_data  = hdr_make(h_size, 1'b1);
                  state_in = S_DONE;
               end
            end else if (step_next < WALK_END) begin
               walk_in = step_next;
               rd_en   = 1'b1;
               rd_addr = step_next[AW-1:0];
            end else begin
               res_status_in = ST_NO_MEM;
               state_in      = S_DONE;
            end
         end
         S_A_SPLIT: begin
            // remainder header of a split block
            wr_en    = 1'b1;
            wr_addr  = split_addr_ff;
            wr_data  = split_data_ff;
            state_in = S_DONE;
         end
         S_F_CHK: begin
            if (h_tag != HDR_TAG) begin
               res_status_in = ST_BAD_PTR;
               state_in      = S_DONE;
            end else if (!h_used) begin
               res_status_in = ST_DOUBLE;
               state_in      = S_DONE;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = idx_ff;
               wr_data       = {rd_data[15:13], 1'b0, rd_data[11:0]};
               res_status_in = ST_OK;
               state_in      = S_M_ISSUE;
            end
         end
         S_M_ISSUE: begin
            rd_en    = 1'b1;
            rd_addr  = walk_ff[AW-1:0];
            state_in = S_M_CUR;
         end
         S_M_CUR: begin
            hi_in = rd_data[15:12];
            if (!h_used && step_next < REGION_W) begin
               // free head: look at the following header
               sacc_in  = h_size;
               jp_in    = step_next;
               rd_en    = 1'b1;
               rd_addr  = step_next[AW-1:0];
               state_in = S_M_J;
            end else if (adv_go) begin
               walk_in = acc_next;
               rd_en   = 1'b1;
               rd_addr = acc_next[AW-1:0];
            end else begin
               state_in = S_DONE;
            end
         end
         S_M_J: begin
            if (!h_used && j_next < REGION_W) begin
               // absorb the free neighbor and keep looking
               sacc_in = s_grow;
               jp_in   = j_next;
               rd_en   = 1'b1;
               rd_addr = j_next[AW-1:0];
            end else begin
               // run ends: commit merged size and move on
               wr_en   = 1'b1;
               wr_addr = walk_ff[AW-1:0];
               wr_data = {hi_ff, h_used ? sacc_ff : s_grow};
               if (adv_go) begin
                  walk_in  = acc_next;
                  rd_en    = 1'b1;
                  rd_addr  = acc_next[AW-1:0];
                  state_in = S_M_CUR;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in                  = 1'b1;
               rsp_payload_in.status         = res_status_ff;
               rsp_payload_in.granted_offset = res_granted_ff;
               state_in                      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff        <= walk_in;
      jp_ff          <= jp_in;
      sacc_ff        <= sacc_in;
      hi_ff          <= hi_in;
      rsize_ff       <= rsize_in;
      idx_ff         <= idx_in;
      split_addr_ff  <= split_addr_in;
      split_data_ff  <= split_data_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `include "assert_macros.svh"

   // no request is taken while the memory is being cleared
   `FFBA_ASSERT_IMPL(a_clear_blocks, clock, reset, state_ff == S_CLEAR, req_stall, "request taken during clearing pass")
   // a grant only comes with ok status
   `FFBA_ASSERT_IMPL(a_grant_ok, clock, reset, rsp_valid && rsp_payload.granted_offset != 12'd0, rsp_payload.status == ST_OK, "granted offset without ok status")
   // a finished request loads its reply and frees the input side
   `FFBA_ASSERT_NEXT(a_done_loads, clock, reset, state_ff == S_DONE && out_free, rsp_valid_ff && state_ff == S_IDLE, "result not loaded on completion")
endmodule

>>> rtl/ffba_hdr_ram.sv
`timescale 1ns / 1ps
module ffba_hdr_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data
);
   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

   `include "assert_macros.svh"

   `FFBA_ASSERT_IMPL(a_no_rw_collision, clock, 1'b0, rd_en && wr_en, rd_addr != wr_addr, "read and write hit the same header in one cycle")
endmodule

>>> tb/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps
module tb_first_fit_block_allocator;
   import ffba_pkg::*;

   localparam int REGION = 4096;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   first_fit_block_allocator #(.REGION_BYTES(REGION)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // one directed row: a request plus, where obvious, the reply it must give
   typedef struct {
      logic        op;
      int          size;
      int          offset;
      bit          typed;
      logic [2:0]  status;
      logic [11:0] granted;
   } dir_row_type;

   logic [15:0] hdr_mem [REGION];   // predicted header store
   rsp_type     pending_rsp [$];    // replies still owed by the block
   int          live_offsets [$];   // data offsets currently allocated
   int          freed_offsets [$];  // offsets released earlier, for double frees
   int          errors = 0;
   int          rsp_count = 0;
   bit          stim_done = 0;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic logic [15:0] make_hdr(int size, logic used);
      logic [11:0] sz;
      sz = size[11:0];
      return {HDR_TAG, used, sz};
   endfunction

   // one pass over the chain joining every run of free neighbors
   function automatic void coalesce();
      int          i;
      int          j;
      int          s;
      logic [15:0] cur;
      logic [15:0] nxt;
      i = 0;
      do begin
         cur = hdr_mem[i];
         if (!cur[12]) begin
            s = cur[11:0];
            j = i + 2 + s;
            while (j < REGION) begin
               nxt = hdr_mem[j];
               if (nxt[12])
                  break;
               s = (s + 2 + nxt[11:0]) & 12'hfff;
               j = j + nxt[11:0] + 2;
            end
            cur = {cur[15:12], s[11:0]};
            hdr_mem[i] = cur;
         end
         i = i + 2 + cur[11:0];
      end while (i < REGION);
   endfunction

   // first-fit search with split when more than a header's worth is left
   function automatic rsp_type predict_alloc(int req);
      rsp_type r;
      int      i;
      int      s;
      int      nx;
      r.status = ST_NO_MEM;
      r.granted_offset = '0;
      if (req == 0 || req > REGION - 2) begin
         r.status = ST_BAD_SIZE;
         return r;
      end
      // first allocate sets up the whole region as one free block
      if (hdr_mem[0][15:13] != HDR_TAG)
         hdr_mem[0] = make_hdr(REGION - 2, 1'b0);
      i = 0;
      do begin
         s = hdr_mem[i][11:0];
         if (!hdr_mem[i][12] && s >= req) begin
            r.status = ST_OK;
            r.granted_offset = 12'(i + 2);
            if (s - req > 2) begin
               nx = i + 2 + req;
               hdr_mem[i] = make_hdr(req, 1'b1);
               if (nx < REGION)
                  hdr_mem[nx] = make_hdr(s - req - 2, 1'b0);
            end else begin
               hdr_mem[i] = make_hdr(s, 1'b1);
            end
            return r;
         end
         i = i + 2 + s;
      end while (i < REGION - 2);
      return r;
   endfunction

   function automatic rsp_type predict_release(int offset);
      rsp_type r;
      int      idx;
      r.granted_offset = '0;
      idx = (offset - 2) & 16'hffff;
      // null pointers wrap to a large index; this check catches any index past the region
      if (idx >= REGION)
         r.status = ST_BAD_PTR;
      else if (hdr_mem[idx][15:13] != HDR_TAG)
         r.status = ST_BAD_PTR;
      else if (!hdr_mem[idx][12])
         r.status = ST_DOUBLE;
      else begin
         r.status = ST_OK;
         hdr_mem[idx][12] = 1'b0;
         coalesce();
      end
      return r;
   endfunction

   // present one request, wait for acceptance, then book its expected reply
   task automatic send_request(logic op, int size, int offset, bit typed,
                               rsp_type typed_rsp, int gap);
      rsp_type predicted;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload.operation <= op;
      req_payload.request_size <= size[15:0];
      req_payload.release_offset <= offset[15:0];
      do @(posedge clock); while (req_stall);
      if (op == OP_ALLOC) begin
         predicted = predict_alloc(size & 16'hffff);
         if (predicted.status == ST_OK)
            live_offsets.push_back(predicted.granted_offset);
      end else begin
         predicted = predict_release(offset & 16'hffff);
         if (predicted.status == ST_OK)
            freed_offsets.push_back(offset);
      end
      pending_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   // gaps vanish for one stretch in every three
   function automatic int draw_gap(int n);
      return ((n / 100) % 3 == 1) ? 0 : $urandom_range(0, 9);
   endfunction

   // stimulus
   initial begin
      dir_row_type dir_rows [$];
      rsp_type     tr;
      int          k;
      int          pick;
      int          sel;
      logic        op;
      int          size;
      int          offset;
      int          cap [6];
      cap = '{1, 2, 3, 4092, 4093, 4094};
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      // null, untagged, size range, whole region, full region, double free
      dir_rows = '{
         '{OP_FREE,  0,     0,     1, ST_BAD_PTR,  12'd0},
         '{OP_FREE,  0,     2,     1, ST_BAD_PTR,  12'd0},
         '{OP_ALLOC, 0,     0,     1, ST_BAD_SIZE, 12'd0},
         '{OP_ALLOC, 4095,  0,     1, ST_BAD_SIZE, 12'd0},
         '{OP_ALLOC, 65535, 65535, 1, ST_BAD_SIZE, 12'd0},
         '{OP_ALLOC, 4094,  0,     1, ST_OK,       12'd2},
         '{OP_ALLOC, 1,     0,     1, ST_NO_MEM,   12'd0},
         '{OP_FREE,  0,     65535, 1, ST_BAD_PTR,  12'd0},
         '{OP_FREE,  0,     1,     1, ST_BAD_PTR,  12'd0},
         '{OP_FREE,  0,     2,     1, ST_OK,       12'd0},
         '{OP_FREE,  0,     2,     1, ST_DOUBLE,   12'd0},
         '{OP_ALLOC, 4092,  0,     1, ST_OK,       12'd2},
         '{OP_FREE,  65535, 2,     1, ST_OK,       12'd0},
         '{OP_ALLOC, 4091,  0,     1, ST_OK,       12'd2},
         '{OP_FREE,  0,     4097,  0, ST_OK,       12'd0},
         '{OP_FREE,  0,     2,     0, ST_OK,       12'd0},
         '{OP_ALLOC, 1,     0,     0, ST_OK,       12'd0},
         '{OP_ALLOC, 1,     0,     0, ST_OK,       12'd0},
         '{OP_FREE,  0,     3,     0, ST_OK,       12'd0},
         '{OP_ALLOC, 4093,  0,     0, ST_OK,       12'd0},
         '{OP_FREE,  0,     5,     0, ST_OK,       12'd0},
         '{OP_FREE,  0,     2,     0, ST_OK,       12'd0},
         '{OP_ALLOC, 100,   43690, 0, ST_OK,       12'd0},
         '{OP_FREE,  21845, 2,     0, ST_OK,       12'd0}
      };
      for (k = 0; k < REGION; k++)
         hdr_mem[k] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         tr.status = dir_rows[r].status;
         tr.granted_offset = dir_rows[r].granted;
         send_request(dir_rows[r].op, dir_rows[r].size, dir_rows[r].offset,
                      dir_rows[r].typed, tr, $urandom_range(0, 9));
      end
      live_offsets.delete();

      // random part: mostly sensible traffic, some garbage pointers and sizes
      for (k = 0; k < 850; k++) begin
         op = ($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_FREE;
         size = $urandom & 16'hffff;
         offset = $urandom & 16'hffff;
         sel = $urandom_range(0, 99);
         if (op == OP_ALLOC) begin
            if (sel < 80)
               size = $urandom_range(1, 160);
            else if (sel < 90)
               size = $urandom_range(1, REGION - 2);
            else if (sel < 95)
               size = cap[$urandom_range(0, 5)];
         end else begin
            if (sel < 75 && live_offsets.size() > 0) begin
               pick = $urandom_range(0, live_offsets.size() - 1);
               offset = live_offsets[pick];
               live_offsets.delete(pick);
            end else if (sel < 88 && freed_offsets.size() > 0) begin
               offset = freed_offsets[$urandom_range(0, freed_offsets.size() - 1)];
            end
         end
         send_request(op, size, offset, 1'b0, tr, draw_gap(k));
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   // reply side: random stall before each reply, compare in order
   initial begin
      int      n;
      rsp_type want;
      rsp_stall = 1'b0;
      forever begin
         n = draw_gap(rsp_count);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected reply status=%0d granted_offset=%0d",
                   rsp_payload.status, rsp_payload.granted_offset);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_payload.status);
               errors++;
            end
            if (rsp_payload.granted_offset !== want.granted_offset) begin
               $error("granted_offset expected %0d actual %0d",
                      want.granted_offset, rsp_payload.granted_offset);
               errors++;
            end
         end
      end
   end

   // end of run once every reply is in
   initial begin
      wait (stim_done);
      while (pending_rsp.size() > 0)
         @(posedge clock);
      repeat (8200) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #200ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/ffba_pkg.sv
rtl/ffba_hdr_ram.sv
rtl/first_fit_block_allocator.sv
tb/tb_first_fit_block_allocator.sv
